// ----- sv/fvcw_pkg.sv -----
// Shared types, constants and color wheel table for the flow color wheel block.
package fvcw_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int CNT_W            = 5;
  localparam logic [31:0] ONE     = 32'(1) << FRAC_BITS;

  localparam int RY = 15;
  localparam int YG = 6;
  localparam int GC = 4;
  localparam int CB = 11;
  localparam int BM = 13;
  localparam int MR = 6;
  localparam int NCOLS = RY + YG + GC + CB + BM + MR;

  localparam logic [7:0] NCOLS_M1 = 8'(NCOLS - 1);

  // atan(2^-i) in turns, scaled by 2^32
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680094, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic               mode;
    logic               frame_start;
    logic signed [31:0] flow_x;
    logic signed [31:0] flow_y;
    logic               flow_valid;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pixel_colored;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul_x;
    logic mul_y;
    logic mul_r;
    logic sqrt_step;
    logic max_upd;
    logic div_step;
    logic calc_p;
    logic calc_c;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic out_free;
    logic iter_done;
    logic div_done;
  } sts_t;

  // Wheel entry k as {red, green, blue}; elaboration time only
  function automatic logic [23:0] wheel_entry(input int k);
    int r;
    int g;
    int b;
    if (k < RY) begin
      r = 255; g = 255 * k / RY; b = 0;
    end else if (k < RY + YG) begin
      r = 255 - 255 * (k - RY) / YG; g = 255; b = 0;
    end else if (k < RY + YG + GC) begin
      r = 0; g = 255; b = 255 * (k - RY - YG) / GC;
    end else if (k < RY + YG + GC + CB) begin
      r = 0; g = 255 - 255 * (k - RY - YG - GC) / CB; b = 255;
    end else if (k < RY + YG + GC + CB + BM) begin
      r = 255 * (k - RY - YG - GC - CB) / BM; g = 0; b = 255;
    end else begin
      r = 255; g = 0; b = 255 - 255 * (k - RY - YG - GC - CB - BM) / MR;
    end
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  typedef logic [NCOLS-1:0][23:0] wheel_lut_t;

  function automatic wheel_lut_t wheel_build();
    wheel_lut_t lut;
    for (int k = 0; k < NCOLS; k++) lut[k] = wheel_entry(k);
    return lut;
  endfunction

  localparam wheel_lut_t WHEEL = wheel_build();

  // Wheel entry k, channel ch (0 red, 1 green, 2 blue)
  function automatic logic [7:0] wheel_val(input logic [5:0] k, input logic [1:0] ch);
    logic [23:0] e;
    e = WHEEL[k];
    case (ch)
      2'd0:    return e[23:16];
      2'd1:    return e[15:8];
      default: return e[7:0];
    endcase
  endfunction

endpackage

// ----- sv/fvcw_ctrl.sv -----
// Sequencer for the flow color wheel: steps the datapath through one item.
module fvcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic              in_flow_valid,
  input  fvcw_pkg::sts_t    sts,
  output fvcw_pkg::cmd_t    cmd,
  output logic              busy
);
  import fvcw_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MULX  = 10'b0000000010,
    S_MULY  = 10'b0000000100,
    S_MULR  = 10'b0000001000,
    S_ITER  = 10'b0000010000,
    S_UPD   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_PCALC = 10'b0010000000,
    S_CCALC = 10'b0100000000,
    S_VOUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   color_r, color_nxt;

  always_comb begin
    state_nxt = state_r;
    color_nxt = color_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          color_nxt = in_mode;
          if (in_flow_valid) state_nxt = S_MULX;
          else if (in_mode)  state_nxt = S_VOUT;
        end
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_MULR;
      end
      S_MULR: begin
        cmd.mul_r = 1'b1;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.sqrt_step = 1'b1;
        if (sts.iter_done) begin
          if (!color_r)          state_nxt = S_UPD;
          else if (sts.in_range) state_nxt = S_DIV;
          else                   state_nxt = S_PCALC;
        end
      end
      S_UPD: begin
        cmd.max_upd = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_PCALC;
      end
      S_PCALC: begin
        cmd.calc_p = 1'b1;
        state_nxt  = S_CCALC;
      end
      S_CCALC: begin
        cmd.calc_c = 1'b1;
        state_nxt  = S_VOUT;
      end
      S_VOUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      color_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      color_r <= color_nxt;
    end
  end

endmodule

// ----- sv/fvcw_dp.sv -----
// Datapath: squares, serial square root, CORDIC angle, serial divide, wheel blend.
module fvcw_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fvcw_pkg::in_item_t  in_data,
  input  logic [30:0]         max_motion,
  input  fvcw_pkg::cmd_t      cmd,
  output fvcw_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output fvcw_pkg::out_item_t out_data
);
  import fvcw_pkg::*;

  localparam logic [23:0] FULL = 24'hFF0000;

  logic                valid_r;
  logic [31:0]         absx_r, absy_r;
  logic [31:0]         run_max_r;
  logic [31:0]         range_r;
  logic [63:0]         sqx_r, sqy_r, m2_r, r2_r, sq_sh_r;
  logic [33:0]         rem_r;
  logic [31:0]         root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic signed [63:0]  ax_r, ay_r;
  logic signed [33:0]  z_r;
  logic [1:0]          q_r;
  logic [31:0]         drem_r;
  logic [16:0]         rad_r;
  logic [37:0]         p_r;
  logic [23:0]         c_r [3];
  logic                out_valid_r;
  out_item_t           out_r;

  // multiplier operand select
  logic [31:0] mop;
  logic [63:0] prod;
  assign mop  = cmd.mul_x ? absx_r : (cmd.mul_y ? absy_r : range_r);
  assign prod = 64'(mop) * 64'(mop);

  // square root step
  logic [33:0] srem, strial;
  assign srem   = {rem_r[31:0], sq_sh_r[63:62]};
  assign strial = {root_r, 2'b01};

  // CORDIC step
  logic signed [63:0] dx, dy;
  logic signed [33:0] at;
  logic               cor_on;
  assign dx     = ay_r >>> cnt_r;
  assign dy     = ax_r >>> cnt_r;
  assign at     = signed'(34'(ATAN_TURNS[cnt_r]));
  assign cor_on = (32'(cnt_r) < 32'(ANGLE_ITERATIONS));

  // divide step
  logic [32:0] dnum;
  assign dnum = (cnt_r == '0) ? {1'b0, root_r} : {drem_r, 1'b0};

  // angle clamp
  logic [29:0] tq;
  logic [31:0] t;
  assign tq = z_r[33] ? 30'd0 : ((z_r[32:30] != 3'd0) ? 30'h3FFFFFFF : z_r[29:0]);
  assign t  = {q_r, tq};

  // range select
  logic [31:0] rsel;
  always_comb begin
    rsel = (max_motion != '0) ? {1'b0, max_motion} : run_max_r;
    if (rsel == '0) rsel = 32'd1;
  end

  // quadrant fold of the input vector
  logic signed [63:0] sx, sy, qx, qy;
  logic [1:0]         qq;
  always_comb begin
    sx = 64'(in_data.flow_x);
    sy = 64'(in_data.flow_y);
    if (sy > 0 && sx <= 0) begin
      qq = 2'd1; qx = sy; qy = -sx;
    end else if (sx < 0 && sy <= 0) begin
      qq = 2'd2; qx = -sx; qy = -sy;
    end else if (sx >= 0 && sy < 0) begin
      qq = 2'd3; qx = -sy; qy = sx;
    end else begin
      qq = 2'd0; qx = sx; qy = sy;
    end
  end

  // wheel blend
  logic [5:0]  k0, k1;
  logic [16:0] f16, f16n;
  assign k0   = p_r[37:32];
  assign k1   = k0 + 6'd1;
  assign f16  = {1'b0, p_r[31:16]};
  assign f16n = 17'h10000 - f16;

  logic        in_range;
  assign in_range = (m2_r <= r2_r);

  logic [40:0] sc [3];
  logic [23:0] vch [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sc[ch] = 41'(FULL - c_r[ch]) * 41'(rad_r);
      if (in_range) vch[ch] = FULL - 24'(sc[ch] >> 16);
      else          vch[ch] = 24'((26'(c_r[ch]) * 26'd3) >> 2);
    end
  end

  assign sts.in_range  = in_range;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.iter_done = (cnt_r == {CNT_W{1'b1}});
  assign sts.div_done  = (cnt_r == CNT_W'(16));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r   <= ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_data.frame_start) run_max_r <= ONE;
      if (cmd.max_upd && root_r > run_max_r) run_max_r <= root_r;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      valid_r <= in_data.flow_valid;
      absx_r  <= in_data.flow_x[31] ? 32'(-in_data.flow_x) : 32'(in_data.flow_x);
      absy_r  <= in_data.flow_y[31] ? 32'(-in_data.flow_y) : 32'(in_data.flow_y);
      q_r     <= qq;
      ax_r    <= qx <<< 28;
      ay_r    <= qy <<< 28;
      z_r     <= '0;
    end
    if (cmd.mul_x) begin
      sqx_r   <= prod;
      range_r <= rsel;
    end
    if (cmd.mul_y) sqy_r <= prod;
    if (cmd.mul_r) begin
      r2_r    <= prod;
      m2_r    <= sqx_r + sqy_r;
      sq_sh_r <= sqx_r + sqy_r;
      rem_r   <= '0;
      root_r  <= '0;
      cnt_r   <= '0;
      rad_r   <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_sh_r <= sq_sh_r << 2;
      if (srem >= strial) begin
        rem_r  <= srem - strial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= srem;
        root_r <= {root_r[30:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
      if (cor_on) begin
        if (ay_r > 0) begin
          ax_r <= ax_r + dx; ay_r <= ay_r - dy; z_r <= z_r + at;
        end else if (ay_r < 0) begin
          ax_r <= ax_r - dx; ay_r <= ay_r + dy; z_r <= z_r - at;
        end
      end
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (dnum >= {1'b0, range_r}) begin
        drem_r <= 32'(dnum - {1'b0, range_r});
        rad_r  <= {rad_r[15:0], 1'b1};
      end else begin
        drem_r <= dnum[31:0];
        rad_r  <= {rad_r[15:0], 1'b0};
      end
    end
    if (cmd.calc_p) p_r <= 38'(t) * 38'(NCOLS_M1);
    if (cmd.calc_c) begin
      for (int ch = 0; ch < 3; ch++) begin
        c_r[ch] <= 24'(25'(wheel_val(k0, 2'(ch))) * 25'(f16n)
                     + 25'(wheel_val(k1, 2'(ch))) * 25'(f16));
      end
    end
    if (cmd.emit) begin
      if (valid_r) begin
        out_r.red           <= vch[0][23:16];
        out_r.green         <= vch[1][23:16];
        out_r.blue          <= vch[2][23:16];
        out_r.pixel_colored <= 1'b1;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/flow_vector_color_wheel.sv -----
// Flow vector color wheel: top level with config register, sequencer and datapath.
// Each accepted beat is one flow vector. A measure beat (mode 0) gives no output;
// a valid one runs three squarings on the shared 32x32 multiplier, 32 steps
// of the bit-serial square root and one max update; an invalid one is
// absorbed in its accept cycle. A color beat gives one output beat: a valid
// vector inside the range runs squaring, 32 root steps with the 16-step
// CORDIC running alongside, 17 divide steps, wheel lookup and blend; one
// beyond the range skips the divide, and an invalid vector goes straight to
// the output state and out black. One beat is in flight at a time; the
// finished pixel waits in the output register so the next beat is taken
// meanwhile.
// frame_start resets the running maximum to 1.0 before the beat it comes with.
// max_motion (APB byte address 0, Q15.16) fixes the range; zero uses the
// measured maximum. Write it only while the block is idle.
module flow_vector_color_wheel (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fvcw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fvcw_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import fvcw_pkg::*;

  logic [30:0] max_motion_r;
  cmd_t        cmd;
  sts_t        sts;
  logic        busy;
  logic        cfg_wr;

  // single register, so every word address maps to it
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {1'b0, max_motion_r} | {30'd0, cfg_paddr & 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) max_motion_r <= '0;
    else if (cfg_wr) max_motion_r <= cfg_pwdata[30:0];
  end

  fvcw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_mode       (in_data.mode),
    .in_flow_valid (in_data.flow_valid),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy)
  );

  fvcw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .max_motion (max_motion_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign in_stall = busy;

  // a valid vector always leads to a busy block for the following cycle
  a_busy_after_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.flow_valid |=> in_stall)
    else $error("block idle right after a valid beat");

  // uncolored pixels are black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pixel_colored |->
      out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
    else $error("uncolored pixel not black");

  // a new result only appears while a beat is being worked on
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule
